// ===== hw/rtl/sel_pkg.sv =====
// ----------------------------------------------------------------------------
// sel_pkg
// Shared types, widths and register codes for the sample expander.
// ----------------------------------------------------------------------------
package sel_pkg;

    localparam int MAX_OUTPUT_SAMPLES = 1048576;
    localparam int RATIO_FRAC_BITS    = 8;
    localparam int PER_CALL_LIMIT     = 16;

    localparam int IDX_W   = 20;
    localparam int STEP_W  = 16;
    localparam int ALPHA_W = 17;
    localparam int SMP_W   = 16;
    localparam int CNT_W   = $clog2(PER_CALL_LIMIT + 1);
    localparam int MAXC_W  = $clog2(MAX_OUTPUT_SAMPLES + 1);
    localparam int LIM_W   = (MAXC_W > IDX_W) ? MAXC_W : IDX_W + 1;

    localparam int ADDR_W  = 4;
    localparam int DATA_W  = 32;

    // shared multiplier operand widths
    localparam int MUL_A_W = IDX_W + 1;
    localparam int MUL_B_W = ALPHA_W + 1;
    localparam int PROD_W  = MUL_A_W + MUL_B_W;
    localparam int ACC_W   = PROD_W + 1;

    localparam logic [IDX_W-1:0]   IDX_MAX     = {IDX_W{1'b1}};
    localparam logic [ALPHA_W-1:0] ALPHA_UNITY = ALPHA_W'(65536);

    typedef enum logic [1:0] {
        REG_STEP  = 2'd0,
        REG_LEN   = 2'd1,
        REG_ALPHA = 2'd2,
        REG_MODE  = 2'd3
    } t_reg_idx;

    typedef struct packed {
        logic [STEP_W-1:0]  step_ratio;
        logic [IDX_W-1:0]   out_length;
        logic [ALPHA_W-1:0] filter_alpha;
        logic               sample_width_mode;
    } t_cfg;

    typedef struct packed {
        logic signed [MUL_A_W-1:0] a;
        logic signed [MUL_B_W-1:0] b;
    } t_mul_op;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_MUL,
        ST_CHECK,
        ST_EMIT_MID,
        ST_FILT,
        ST_FFIN,
        ST_EMIT_LAST
    } t_state;

endpackage

// ===== hw/rtl/sel_if.sv =====
// ----------------------------------------------------------------------------
// sel_if
// Valid/ready channels for source samples and resampled output requests.
// ----------------------------------------------------------------------------
interface sel_in_if;
    logic        valid;
    logic        ready;
    logic [15:0] sample_value;
    logic        first;

    modport source (output valid, output sample_value, output first, input ready);
    modport sink   (input valid, input sample_value, input first, output ready);
endinterface

interface sel_out_if;
    logic               valid;
    logic               ready;
    logic signed [15:0] left_sample;
    logic signed [15:0] right_sample;
    logic               last_of_run;
    logic               sound_done;

    modport source (output valid, output left_sample, output right_sample,
                    output last_of_run, output sound_done, input ready);
    modport sink   (input valid, input left_sample, input right_sample,
                    input last_of_run, input sound_done, output ready);
endinterface

// ===== hw/rtl/sel_regs.sv =====
// ----------------------------------------------------------------------------
// sel_regs
// APB configuration registers: step ratio, length, filter alpha, width mode.
// ----------------------------------------------------------------------------
module sel_regs (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sel_pkg::ADDR_W-1:0] paddr,
    input  logic [sel_pkg::DATA_W-1:0] pwdata,
    output logic [sel_pkg::DATA_W-1:0] prdata,
    output logic                       pready,
    output sel_pkg::t_cfg              o_cfg
);

    sel_pkg::t_cfg r_cfg;
    sel_pkg::t_cfg n_cfg;
    logic          wr_en;
    logic [1:0]    reg_sel;

    assign pready  = 1'b1;
    assign wr_en   = psel & penable & pwrite;
    assign reg_sel = paddr[3:2];
    assign o_cfg   = r_cfg;

    always_comb begin
        n_cfg = r_cfg;
        if (wr_en) begin
            case (reg_sel)
                sel_pkg::REG_STEP:  n_cfg.step_ratio   = pwdata[sel_pkg::STEP_W-1:0];
                sel_pkg::REG_LEN:   n_cfg.out_length   = pwdata[sel_pkg::IDX_W-1:0];
                sel_pkg::REG_ALPHA: n_cfg.filter_alpha = pwdata[sel_pkg::ALPHA_W-1:0];
                sel_pkg::REG_MODE:  n_cfg.sample_width_mode = pwdata[0];
                default:            n_cfg = r_cfg;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.step_ratio        <= sel_pkg::STEP_W'(256);
            r_cfg.out_length        <= '0;
            r_cfg.filter_alpha      <= sel_pkg::ALPHA_W'(32768);
            r_cfg.sample_width_mode <= 1'b0;
        end else begin
            r_cfg <= n_cfg;
        end
    end

    always_comb begin
        prdata = '0;
        case (reg_sel)
            sel_pkg::REG_STEP:  prdata = sel_pkg::DATA_W'(r_cfg.step_ratio);
            sel_pkg::REG_LEN:   prdata = sel_pkg::DATA_W'(r_cfg.out_length);
            sel_pkg::REG_ALPHA: prdata = sel_pkg::DATA_W'(r_cfg.filter_alpha);
            sel_pkg::REG_MODE:  prdata = sel_pkg::DATA_W'(r_cfg.sample_width_mode);
            default:            prdata = '0;
        endcase
    end

endmodule

// ===== hw/rtl/sel_mul.sv =====
// ----------------------------------------------------------------------------
// sel_mul
// Shared signed multiplier with registered product.
// ----------------------------------------------------------------------------
module sel_mul (
    input  logic                              i_clk,
    input  sel_pkg::t_mul_op                  i_op,
    output logic signed [sel_pkg::PROD_W-1:0] o_prod
);

    logic signed [sel_pkg::PROD_W-1:0] r_prod;
    logic signed [sel_pkg::PROD_W-1:0] n_prod;

    assign n_prod = sel_pkg::PROD_W'(i_op.a) * sel_pkg::PROD_W'(i_op.b);
    assign o_prod = r_prod;

    always_ff @(posedge i_clk) begin
        r_prod <= n_prod;
    end

endmodule

// ===== hw/rtl/sel_seq.sv =====
// ----------------------------------------------------------------------------
// sel_seq
// Sequencer: index bookkeeping, source select test, one-pole filter, output.
// ----------------------------------------------------------------------------
module sel_seq (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  sel_pkg::t_cfg                     i_cfg,
    sel_in_if.sink                            i_in,
    sel_out_if.source                         o_out,
    output sel_pkg::t_mul_op                  o_mul,
    input  logic signed [sel_pkg::PROD_W-1:0] i_prod
);

    localparam int IW = sel_pkg::IDX_W;
    localparam int LW = sel_pkg::LIM_W;
    localparam int SW = sel_pkg::SMP_W;
    localparam int AW = sel_pkg::ACC_W;
    localparam int SRC_W = sel_pkg::PROD_W - sel_pkg::RATIO_FRAC_BITS;

    sel_pkg::t_state r_state, n_state;

    logic [IW-1:0]                r_oi, n_oi;
    logic [IW-1:0]                r_si, n_si;
    logic signed [SW-1:0]         r_prev, n_prev;
    logic signed [SW-1:0]         r_x, n_x;
    logic [sel_pkg::CNT_W-1:0]    r_cnt, n_cnt;
    logic                         r_pend, n_pend;
    logic signed [SW-1:0]         r_y, n_y;
    logic                         r_sd, n_sd;

    logic [LW-1:0]                lim;
    logic [LW-1:0]                oi_ext;
    logic [SRC_W-1:0]             src;
    logic                         go_on;
    logic [sel_pkg::ALPHA_W-1:0]  alpha_sat;
    logic signed [SW:0]           diff;
    logic signed [AW-1:0]         acc;
    logic signed [AW-17:0]        quo;
    logic signed [SW-1:0]         y_filt;
    logic signed [SW-1:0]         x_wide;
    logic                         accept;
    logic                         out_take;

    // effective length is out_length capped at the output limit
    always_comb begin
        if (LW'(i_cfg.out_length) < LW'(sel_pkg::MAX_OUTPUT_SAMPLES)) begin
            lim = LW'(i_cfg.out_length);
        end else begin
            lim = LW'(sel_pkg::MAX_OUTPUT_SAMPLES);
        end
    end

    assign oi_ext = LW'(r_oi);
    assign src    = SRC_W'(i_prod >>> sel_pkg::RATIO_FRAC_BITS);
    assign go_on  = (r_cnt < sel_pkg::CNT_W'(sel_pkg::PER_CALL_LIMIT))
                  && (oi_ext < lim) && (src <= SRC_W'(r_si));

    assign alpha_sat = (i_cfg.filter_alpha > sel_pkg::ALPHA_UNITY)
                     ? sel_pkg::ALPHA_UNITY : i_cfg.filter_alpha;
    assign diff      = (SW+1)'(r_x) - (SW+1)'(r_prev);

    // prev*65536 + alpha*(x-prev), then divide truncating toward zero
    assign acc    = AW'(i_prod) + (AW'(r_prev) <<< 16);
    assign quo    = (AW-16)'(acc >>> 16)
                  + (AW-16)'((acc < 0) && (acc[15:0] != 16'd0));
    assign y_filt = quo[SW-1:0];

    // 8-bit: b*257-32768 is the byte doubled with the top bit flipped
    assign x_wide = i_cfg.sample_width_mode ? i_in.sample_value
                  : {~i_in.sample_value[7], i_in.sample_value[6:0], i_in.sample_value[7:0]};

    assign accept   = i_in.valid & i_in.ready;
    assign out_take = o_out.valid & o_out.ready;

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            sel_pkg::ST_IDLE:      if (accept) n_state = sel_pkg::ST_MUL;
            sel_pkg::ST_MUL:       n_state = sel_pkg::ST_CHECK;
            sel_pkg::ST_CHECK: begin
                if (go_on) begin
                    n_state = r_pend ? sel_pkg::ST_EMIT_MID : sel_pkg::ST_FILT;
                end else begin
                    n_state = r_pend ? sel_pkg::ST_EMIT_LAST : sel_pkg::ST_IDLE;
                end
            end
            sel_pkg::ST_EMIT_MID:  if (out_take) n_state = sel_pkg::ST_FILT;
            sel_pkg::ST_FILT:      n_state = sel_pkg::ST_FFIN;
            sel_pkg::ST_FFIN:      n_state = sel_pkg::ST_MUL;
            sel_pkg::ST_EMIT_LAST: if (out_take) n_state = sel_pkg::ST_IDLE;
            default:               n_state = sel_pkg::ST_IDLE;
        endcase
    end

    // outputs and datapath updates
    always_comb begin
        n_oi   = r_oi;
        n_si   = r_si;
        n_prev = r_prev;
        n_x    = r_x;
        n_cnt  = r_cnt;
        n_pend = r_pend;
        n_y    = r_y;
        n_sd   = r_sd;

        i_in.ready  = 1'b0;
        o_out.valid = 1'b0;
        o_out.last_of_run = 1'b0;
        o_mul.a = sel_pkg::MUL_A_W'(r_oi);
        o_mul.b = sel_pkg::MUL_B_W'(i_cfg.step_ratio);

        case (r_state)
            sel_pkg::ST_IDLE: begin
                i_in.ready = 1'b1;
                if (accept) begin
                    if (i_in.first) begin
                        n_oi   = '0;
                        n_si   = '0;
                        n_prev = '0;
                    end
                    n_x    = x_wide;
                    n_cnt  = '0;
                    n_pend = 1'b0;
                end
            end
            sel_pkg::ST_CHECK: begin
                if (!go_on && !r_pend && (r_si != sel_pkg::IDX_MAX)) begin
                    n_si = r_si + 1'b1;
                end
            end
            sel_pkg::ST_EMIT_MID: begin
                o_out.valid = 1'b1;
            end
            sel_pkg::ST_FILT: begin
                o_mul.a = sel_pkg::MUL_A_W'(diff);
                o_mul.b = sel_pkg::MUL_B_W'(alpha_sat);
            end
            sel_pkg::ST_FFIN: begin
                n_y    = (r_oi == '0) ? r_x : y_filt;
                n_prev = n_y;
                n_sd   = (oi_ext + 1'b1) == lim;
                n_oi   = r_oi + 1'b1;
                n_cnt  = r_cnt + 1'b1;
                n_pend = 1'b1;
            end
            sel_pkg::ST_EMIT_LAST: begin
                o_out.valid       = 1'b1;
                o_out.last_of_run = 1'b1;
                if (out_take && (r_si != sel_pkg::IDX_MAX)) begin
                    n_si = r_si + 1'b1;
                end
            end
            default: begin
                n_pend = r_pend;
            end
        endcase
    end

    assign o_out.left_sample  = r_y;
    assign o_out.right_sample = r_y;
    assign o_out.sound_done   = r_sd;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sel_pkg::ST_IDLE;
            r_oi    <= '0;
            r_si    <= '0;
            r_prev  <= '0;
            r_cnt   <= '0;
            r_pend  <= 1'b0;
        end else begin
            r_state <= n_state;
            r_oi    <= n_oi;
            r_si    <= n_si;
            r_prev  <= n_prev;
            r_cnt   <= n_cnt;
            r_pend  <= n_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        r_x  <= n_x;
        r_y  <= n_y;
        r_sd <= n_sd;
    end

endmodule

// ===== hw/rtl/sample_expander_lowpass.sv =====
// ----------------------------------------------------------------------------
// sample_expander_lowpass
// Nearest-neighbour resampler with a one-pole low-pass on each output.
// ----------------------------------------------------------------------------
// Source samples enter on i_in (valid/ready); each one yields zero to sixteen
// output requests on o_out, the same filtered value on both channels, with
// last_of_run marking the final request made from that sample and
// sound_done marking output number out_length. Registers are written over
// the APB port; the user must write them only while the block is idle, as
// the block does not enforce this. The block takes one sample at a time:
// i_in.ready is high only when idle. Each output passes through the shared
// multiplier sequencer steps index product, select test, filter product,
// filter finish and presentation, and presentation waits for as long as the
// receiver holds off ready; each sample ends with a final index product and
// select test. A stalled receiver simply freezes the sequencer with the
// request held. Reset clears indices, filter history and registers to their
// defaults.
// ----------------------------------------------------------------------------
module sample_expander_lowpass (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    sel_in_if.sink                     i_in,
    sel_out_if.source                  o_out,
    input  logic                       psel,
    input  logic                       penable,
    input  logic                       pwrite,
    input  logic [sel_pkg::ADDR_W-1:0] paddr,
    input  logic [sel_pkg::DATA_W-1:0] pwdata,
    output logic [sel_pkg::DATA_W-1:0] prdata,
    output logic                       pready
);

    sel_pkg::t_cfg                     cfg;
    sel_pkg::t_mul_op                  mul_op;
    logic signed [sel_pkg::PROD_W-1:0] prod;

    sel_regs u_regs (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .o_cfg   (cfg)
    );

    sel_mul u_mul (
        .i_clk  (i_clk),
        .i_op   (mul_op),
        .o_prod (prod)
    );

    sel_seq u_seq (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (cfg),
        .i_in    (i_in),
        .o_out   (o_out),
        .o_mul   (mul_op),
        .i_prod  (prod)
    );

endmodule

// ===== tb/sv/tb_sample_expander_lowpass.sv =====
// ----------------------------------------------------------------------------
// tb_sample_expander_lowpass
// Self-checking bench for the nearest-neighbour resampler with low-pass.
// ----------------------------------------------------------------------------
// A short table of sample requests and register writes is walked first. Only
// the obvious rows carry a hand-written first output, which is unfiltered
// after a restart. Random sounds follow, each with its own register settings.
// Every accepted request is run through an in-bench predictor, and each
// output request is checked field by field against the oldest prediction.
// Both sides idle at random. One sound has a long output stall. Another
// pauses its input until every pending output has drained.
// ----------------------------------------------------------------------------
module tb_sample_expander_lowpass;
    import sel_pkg::*;

    localparam int CYCLE_LIMIT        = 500000;
    localparam int SETTLE_CYCLES      = 100;
    localparam int LONG_HOLD          = 300;
    localparam int RANDOM_ITEMS       = 120;

    typedef struct packed {
        logic signed [SMP_W-1:0] left;
        logic signed [SMP_W-1:0] right;
        logic                    last;
        logic                    done;
    } t_out_word;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind         kind;
        t_reg_idx          reg_idx;
        logic [DATA_W-1:0] data;
        logic              first;
        logic              has_exp;
        int                exp_left;
    } t_stim_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              psel;
    logic              penable;
    logic              pwrite;
    logic [ADDR_W-1:0] paddr;
    logic [DATA_W-1:0] pwdata;
    logic [DATA_W-1:0] prdata;
    logic              pready;

    sel_in_if  in_ch ();
    sel_out_if out_ch ();

    sample_expander_lowpass dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    // predictor copy of the registers and the running state
    logic [STEP_W-1:0]  step_set;
    logic [IDX_W-1:0]   len_set;
    logic [ALPHA_W-1:0] alpha_set;
    logic               wide_mode;
    logic [IDX_W-1:0]   pos_out;
    logic [IDX_W-1:0]   pos_src;
    int                 last_y;

    t_out_word due_q[$];
    t_stim_row directed_rows[$];

    int mismatches;
    int items_sent;
    bit tx_idle;
    bit rx_idle;
    bit long_hold;

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    task automatic report(input string what, input int got, input int want);
        mismatches++;
        $display("[%0t] mismatch on %s: got %0d, expected %0d", $time, what, got, want);
    endtask

    function automatic void add_sample(input logic [SMP_W-1:0] raw, input logic restart,
                                       input logic has_exp, input int exp_left);
        t_stim_row row;
        row.kind     = ROW_SAMPLE;
        row.reg_idx  = REG_STEP;
        row.data     = DATA_W'(raw);
        row.first    = restart;
        row.has_exp  = has_exp;
        row.exp_left = exp_left;
        directed_rows.push_back(row);
    endfunction

    function automatic void add_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        t_stim_row row;
        row.kind     = ROW_WRITE;
        row.reg_idx  = idx;
        row.data     = value;
        row.first    = 1'b0;
        row.has_exp  = 1'b0;
        row.exp_left = 0;
        directed_rows.push_back(row);
    endfunction

    // Works out every output that one source sample causes and queues them.
    task automatic expand_sample(input logic [SMP_W-1:0] raw, input logic restart,
                                 output int n_out, output int y_first);
        int        x;
        int        y;
        longint    a;
        longint    acc;
        longint    src;
        t_out_word w;
        t_out_word held;
        n_out   = 0;
        y_first = 0;
        held    = '0;
        if (restart) begin
            pos_out = '0;
            pos_src = '0;
            last_y  = 0;
        end
        if (wide_mode)
            x = int'($signed(raw));
        else
            x = int'(raw[7:0]) * 257 - 32768;
        a = (alpha_set > ALPHA_UNITY) ? 64'sd65536 : longint'(alpha_set);
        while (n_out < PER_CALL_LIMIT && pos_out < len_set) begin
            src = (longint'(pos_out) * longint'(step_set)) >> RATIO_FRAC_BITS;
            if (src > longint'(pos_src))
                break;
            if (pos_out == '0) begin
                y = x;
            end else begin
                acc = a * x + (65536 - a) * last_y;
                y   = int'(acc / 65536);
            end
            last_y  = y;
            w.left  = y[SMP_W-1:0];
            w.right = y[SMP_W-1:0];
            w.last  = 1'b0;
            w.done  = (pos_out + 1 == len_set);
            if (n_out == 0)
                y_first = y;
            else
                due_q.push_back(held);
            held    = w;
            pos_out = pos_out + 1'b1;
            n_out++;
        end
        if (n_out > 0) begin
            held.last = 1'b1;
            due_q.push_back(held);
        end
        if (pos_src < IDX_MAX)
            pos_src = pos_src + 1'b1;
    endtask

    // Called and returns at a falling edge; valid is left high for the caller.
    task automatic push_sample(input logic [SMP_W-1:0] raw, input logic restart,
                               output int n_out, output int y_first);
        int gap;
        gap = tx_idle ? $urandom_range(0, 16) : 0;
        if (gap > 0) begin
            in_ch.valid <= 1'b0;
            repeat (gap) @(negedge i_clk);
        end
        in_ch.valid        <= 1'b1;
        in_ch.sample_value <= raw;
        in_ch.first        <= restart;
        do @(posedge i_clk); while (!in_ch.ready);
        expand_sample(raw, restart, n_out, y_first);
        items_sent++;
        @(negedge i_clk);
    endtask

    task automatic reg_write(input t_reg_idx idx, input logic [DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(negedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        case (idx)
            REG_STEP:  step_set  = value[STEP_W-1:0];
            REG_LEN:   len_set   = value[IDX_W-1:0];
            REG_ALPHA: alpha_set = value[ALPHA_W-1:0];
            REG_MODE:  wide_mode = value[0];
            default: begin
            end
        endcase
        @(negedge i_clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        @(negedge i_clk);
    endtask

    // Drops valid, waits for every pending output, then lets a sample that
    // makes no output finish its select test.
    task automatic settle();
        in_ch.valid <= 1'b0;
        @(negedge i_clk);
        while (due_q.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    initial begin : receiver
        int gap;
        out_ch.ready = 1'b1;
        forever begin
            @(posedge i_clk);
            if ((out_ch.valid && out_ch.ready) || long_hold) begin
                @(negedge i_clk);
                if (long_hold) begin
                    gap       = LONG_HOLD;
                    long_hold = 1'b0;
                end else begin
                    gap = rx_idle ? $urandom_range(0, 16) : 0;
                end
                if (gap > 0) begin
                    out_ch.ready <= 1'b0;
                    repeat (gap) @(negedge i_clk);
                    out_ch.ready <= 1'b1;
                end
            end
        end
    end

    always @(posedge i_clk) begin : check_outputs
        t_out_word want;
        if (i_rst_n && out_ch.valid && out_ch.ready) begin
            if (due_q.size() == 0) begin
                report("output request with none pending", out_ch.left_sample, 0);
            end else begin
                want = due_q.pop_front();
                if (out_ch.left_sample !== want.left)
                    report("left_sample", out_ch.left_sample, want.left);
                if (out_ch.right_sample !== want.right)
                    report("right_sample", out_ch.right_sample, want.right);
                if (out_ch.last_of_run !== want.last)
                    report("last_of_run", out_ch.last_of_run, want.last);
                if (out_ch.sound_done !== want.done)
                    report("sound_done", out_ch.sound_done, want.done);
            end
        end
    end

    initial begin : watchdog
        repeat (CYCLE_LIMIT) @(posedge i_clk);
        $display("Verification failed");
        $finish;
    end

    initial begin : stimulus
        int                n_out;
        int                y_first;
        int                n_items;
        int                ph;
        int                base_items;
        logic [DATA_W-1:0] wr;
        logic [SMP_W-1:0]  raw;
        logic              restart;
        t_stim_row         row;

        i_rst_n            = 1'b0;
        psel               = 1'b0;
        penable            = 1'b0;
        pwrite             = 1'b0;
        paddr              = '0;
        pwdata             = '0;
        in_ch.valid        = 1'b0;
        in_ch.sample_value = '0;
        in_ch.first        = 1'b0;
        tx_idle            = 1'b1;
        rx_idle            = 1'b1;
        long_hold          = 1'b0;
        mismatches         = 0;
        items_sent         = 0;
        step_set           = STEP_W'(256);
        len_set            = '0;
        alpha_set          = ALPHA_W'(32768);
        wide_mode          = 1'b0;
        pos_out            = '0;
        pos_src            = '0;
        last_y             = 0;

        // length zero after reset: nothing comes out
        add_sample(16'h0055, 1'b1, 1'b0, 0);
        // upper bits of the write are dropped, length 64
        add_write(REG_LEN, 32'hFFF0_0040);
        add_sample(16'h0000, 1'b1, 1'b1, -32768);
        add_sample(16'h00FF, 1'b0, 1'b0, 0);
        // 8-bit mode uses the low byte only
        add_sample(16'hFF80, 1'b1, 1'b1, 128);
        add_write(REG_MODE, 32'hFFFF_FFFF);
        add_sample(16'h8000, 1'b1, 1'b1, -32768);
        add_sample(16'h7FFF, 1'b0, 1'b0, 0);
        add_sample(16'h7FFF, 1'b1, 1'b1, 32767);
        // alpha zero holds the previous output
        add_write(REG_ALPHA, 32'h0000_0000);
        add_sample(16'h1234, 1'b0, 1'b1, 32767);
        // alpha above unity saturates: output follows the input
        add_write(REG_ALPHA, 32'h0001_FFFF);
        add_sample(16'hFFFF, 1'b0, 1'b1, -1);
        add_write(REG_ALPHA, 32'h0001_0000);
        // step of 1/16: sixteen outputs per sample
        add_write(REG_STEP, 32'h0000_0010);
        add_sample(16'h4000, 1'b1, 1'b1, 16384);
        add_sample(16'hC000, 1'b0, 1'b0, 0);
        // largest step: the second sample is skipped
        add_write(REG_STEP, 32'h0000_FFFF);
        add_sample(16'h0001, 1'b1, 1'b1, 1);
        add_sample(16'h0002, 1'b0, 1'b0, 0);
        // step 1.5 with a length of five, sound_done on the fifth
        add_write(REG_STEP, 32'h0005_0180);
        add_write(REG_LEN, 32'h0000_0005);
        add_sample(16'h0100, 1'b1, 1'b1, 256);
        for (int k = 1; k < 8; k++)
            add_sample(SMP_W'(k * 16'h0731), 1'b0, 1'b0, 0);
        // length lowered under the output count mid-sound
        add_write(REG_LEN, 32'h0000_0002);
        add_sample(16'h0300, 1'b0, 1'b0, 0);
        add_write(REG_LEN, 32'h000F_FFFF);
        add_write(REG_STEP, 32'h0000_0020);
        add_write(REG_MODE, 32'h0000_0000);
        add_sample(16'h00AA, 1'b1, 1'b1, 10922);
        add_sample(16'h0011, 1'b0, 1'b0, 0);
        // step cut mid-sound: outputs pile up past sixteen and carry over
        add_write(REG_STEP, 32'h0000_0010);
        add_sample(16'h0022, 1'b0, 1'b0, 0);
        add_sample(16'h0033, 1'b0, 1'b0, 0);

        repeat (10) @(negedge i_clk);
        i_rst_n <= 1'b1;
        @(negedge i_clk);

        foreach (directed_rows[k]) begin
            row = directed_rows[k];
            if (row.kind == ROW_WRITE) begin
                settle();
                reg_write(row.reg_idx, row.data);
            end else begin
                push_sample(row.data[SMP_W-1:0], row.first, n_out, y_first);
                if (row.has_exp && (n_out == 0 || y_first != row.exp_left))
                    report("first output of directed sample", y_first, row.exp_left);
            end
        end

        base_items   = items_sent;
        ph           = 0;
        while ((items_sent - base_items) < RANDOM_ITEMS) begin
            settle();
            tx_idle = ($urandom_range(0, 3) != 0);
            rx_idle = ($urandom_range(0, 3) != 0);

            wr = $urandom;
            case ($urandom_range(0, 9))
                0:       wr[STEP_W-1:0] = STEP_W'(16);
                1:       wr[STEP_W-1:0] = {STEP_W{1'b1}};
                2, 3:    wr[STEP_W-1:0] = STEP_W'($urandom_range(16, 255));
                8:       wr[STEP_W-1:0] = STEP_W'($urandom_range(641, 4096));
                9:       wr[STEP_W-1:0] = STEP_W'($urandom_range(16, 65535));
                default: wr[STEP_W-1:0] = STEP_W'($urandom_range(256, 640));
            endcase
            reg_write(REG_STEP, wr);

            wr = $urandom;
            case ($urandom_range(0, 9))
                0:       wr[IDX_W-1:0] = '0;
                1:       wr[IDX_W-1:0] = IDX_MAX;
                2:       wr[IDX_W-1:0] = IDX_W'(1);
                default: wr[IDX_W-1:0] = IDX_W'($urandom_range(8, 160));
            endcase
            // the held sound needs outputs due so that the input backs up
            if (ph == 1)
                wr[IDX_W-1:0] = IDX_W'(64);
            reg_write(REG_LEN, wr);

            wr = $urandom;
            case ($urandom_range(0, 9))
                0:       wr[ALPHA_W-1:0] = '0;
                1:       wr[ALPHA_W-1:0] = ALPHA_UNITY;
                2:       wr[ALPHA_W-1:0] = ALPHA_W'($urandom_range(65537, 131071));
                default: wr[ALPHA_W-1:0] = ALPHA_W'($urandom_range(0, 65536));
            endcase
            reg_write(REG_ALPHA, wr);

            wr = $urandom;
            reg_write(REG_MODE, wr);

            n_items = $urandom_range(8, 24);
            // the block fills and stops taking samples while outputs are held
            if (ph == 1)
                long_hold = 1'b1;
            for (int i = 0; i < n_items; i++) begin
                if (ph == 2 && i == n_items / 2)
                    settle();
                raw     = $urandom;
                restart = (i == 0) ? ((ph == 1) || ($urandom_range(0, 4) != 0))
                                   : ($urandom_range(0, 19) == 0);
                push_sample(raw, restart, n_out, y_first);
            end
            ph++;
        end

        settle();
        if (mismatches == 0)
            $display("Verification passed");
        else
            $display("Verification failed");
        $finish;
    end

endmodule
